/* rtl/tagged_undefined_value_alu_assert.svh */
// Assertion macros for the tagged undefined-value ALU.
// Depends on nothing; included by the top level.
`ifndef TAGGED_UNDEFINED_VALUE_ALU_ASSERT_SVH
`define TAGGED_UNDEFINED_VALUE_ALU_ASSERT_SVH

// Same-cycle implication, held off during reset
`define TUVA_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("tuva assertion failed");

// Next-cycle implication, held off during reset
`define TUVA_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("tuva assertion failed");

`endif

/* rtl/tuva_pkg.sv */
// Shared types and constants of the tagged undefined-value ALU.
// Depends on nothing; used by every module of the block.
package tuva_pkg;

    localparam int FRACTION_BITS_DEF = 24;
    localparam int MUL_LAT = 3;
    localparam int DIV_LAT = 66;
    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [4:0] {
        OP_ADD      = 5'd0,
        OP_SUB      = 5'd1,
        OP_NEG      = 5'd2,
        OP_MUL      = 5'd3,
        OP_DIV      = 5'd4,
        OP_LT       = 5'd5,
        OP_LTE      = 5'd6,
        OP_GT       = 5'd7,
        OP_GTE      = 5'd8,
        OP_EQ       = 5'd9,
        OP_NEQ      = 5'd10,
        OP_AND      = 5'd11,
        OP_OR       = 5'd12,
        OP_NOT      = 5'd13,
        OP_COND     = 5'd14,
        OP_MAX      = 5'd15,
        OP_MIN      = 5'd16,
        OP_PRESENT  = 5'd17,
        OP_NULL     = 5'd18,
        OP_ROUND    = 5'd19,
        OP_FLOOR    = 5'd20,
        OP_DEFTRUE  = 5'd21,
        OP_DEFFALSE = 5'd22
    } op_t;

    // Which unit supplies the final result
    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] value;
        logic        undef;
        logic        sat;
    } side_t;

    // Apply a sign to a 64-bit magnitude and clamp
    function automatic logic [64:0] sign_sat(logic [63:0] mag, logic ovf, logic neg);
        logic [64:0] r;
        if (neg) begin
            if (ovf || mag > Q_MIN) r = {1'b1, Q_MIN};
            else                    r = {1'b0, 64'd0 - mag};
        end
        else begin
            if (ovf || mag[63]) r = {1'b1, Q_MAX};
            else                r = {1'b0, mag};
        end
        return r;
    endfunction

endpackage

/* rtl/tuva_mul.sv */
// Three-stage saturating Q-format magnitude multiplier.
// Depends on tuva_pkg.
module tuva_mul
    import tuva_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] x,
    input  logic [63:0] y,
    input  logic        neg,
    output logic [63:0] value,
    output logic        sat
);

    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic         neg1_reg, neg2_reg;
    logic [127:0] prod_reg;
    logic [127:0] prod_next;
    logic [127:0] shifted;
    logic [64:0]  res_next;
    logic [63:0]  value_reg;
    logic         sat_reg;

    // Stage 1: four 32x32 partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= 64'(x[31:0])  * 64'(y[31:0]);
            lh_reg   <= 64'(x[31:0])  * 64'(y[63:32]);
            hl_reg   <= 64'(x[63:32]) * 64'(y[31:0]);
            hh_reg   <= 64'(x[63:32]) * 64'(y[63:32]);
            neg1_reg <= neg;
        end
    end

    // Stage 2: combine into the full product
    assign prod_next = {hh_reg, 64'd0} + {32'd0, lh_reg, 32'd0}
                     + {32'd0, hl_reg, 32'd0} + {64'd0, ll_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            neg2_reg <= neg1_reg;
        end
    end

    // Stage 3: drop fraction bits, sign and clamp
    assign shifted  = prod_reg >> FRACTION_BITS;
    assign res_next = sign_sat(shifted[63:0], shifted[127:64] != 64'd0, neg2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= res_next[63:0];
            sat_reg   <= res_next[64];
        end
    end

    assign value = value_reg;
    assign sat   = sat_reg;

endmodule

/* rtl/tuva_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with clamp.
// Depends on tuva_pkg.
module tuva_div
    import tuva_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] x,
    input  logic [63:0] d,
    input  logic        neg,
    output logic [63:0] value,
    output logic        sat
);

    localparam int STEPS = 64;

    logic [63:0] rem_reg [0:STEPS-1];
    logic [63:0] num_reg [0:STEPS-1];
    logic [63:0] quo_reg [0:STEPS];
    logic [63:0] den_reg [0:STEPS-1];
    logic        neg_reg [0:STEPS];
    logic        ovf_reg [0:STEPS];
    logic [63:0] num_hi;
    logic [64:0] res_next;
    logic [63:0] value_reg;
    logic        sat_reg;

    // Upper numerator word; a quotient over 64 bits shows as num_hi >= d
    assign num_hi = x >> (64 - FRACTION_BITS);

    // Entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_hi;
            num_reg[0] <= x << FRACTION_BITS;
            quo_reg[0] <= 64'd0;
            den_reg[0] <= d;
            neg_reg[0] <= neg;
            ovf_reg[0] <= num_hi >= d;
        end
    end

    // One quotient bit per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic [63:0] trial;
        logic        ge;
        assign trial = {rem_reg[i][62:0], num_reg[i][63]};
        assign ge    = trial >= den_reg[i];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i+1] <= {quo_reg[i][62:0], ge};
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end

        // Partial remainder and operands go on except after the last bit
        if (i < STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? trial - den_reg[i] : trial;
                    num_reg[i+1] <= {num_reg[i][62:0], 1'b0};
                    den_reg[i+1] <= den_reg[i];
                end
            end
        end
    end

    // Sign and clamp
    assign res_next = sign_sat(quo_reg[STEPS], ovf_reg[STEPS], neg_reg[STEPS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= res_next[63:0];
            sat_reg   <= res_next[64];
        end
    end

    assign value = value_reg;
    assign sat   = sat_reg;

endmodule

/* rtl/tagged_undefined_value_alu.sv */
// Top level of the tagged undefined-value ALU: operand decode and simple ops.
// Depends on tuva_pkg, tuva_mul, tuva_div and the assertion header.
//
// A pipelined ALU over signed Q40.24 values with undefined tags. One item
// can be transferred in every cycle while in_stall is low; an item passes 68
// register stages (one input stage, the 66-stage divider, one output
// register). The pipeline depth is set by the divider, which retires one
// quotient bit per stage; every operation runs through the same pipeline
// so results leave in order. While a result waits on a stalled output the
// whole pipeline holds and in_stall is raised.
`include "tagged_undefined_value_alu_assert.svh"

module tagged_undefined_value_alu
    import tuva_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         operation,
    input  logic signed [63:0] a_value,
    input  logic               a_undef,
    input  logic signed [63:0] b_value,
    input  logic               b_undef,
    input  logic signed [63:0] c_value,
    input  logic               c_undef,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] result_value,
    output logic               result_undef,
    output logic               saturated
);

    localparam int TOTAL = DIV_LAT + 2;
    localparam int MDLY  = DIV_LAT - MUL_LAT;
    localparam logic [63:0] ONE_Q      = 64'd1 << FRACTION_BITS;
    localparam logic [63:0] FRAC_MASK  = ONE_Q - 64'd1;
    localparam logic [63:0] ROUND_BIAS =
        ((64'd50005 << FRACTION_BITS) + 64'd50000) / 64'd100000;
    localparam logic [63:0] FLOOR_EPS  = (ONE_Q + 64'd500000) / 64'd1000000;

    logic        en;
    logic        vld_reg [0:TOTAL-1];

    logic [4:0]  op_reg;
    logic [63:0] a_reg, b_reg, c_reg;
    logic        au_reg, bu_reg, cu_reg;

    logic [63:0] a_mag, b_mag;
    logic        prod_neg, either;
    logic [63:0] sum, diff, rsum, rtrunc, fsum;
    logic        lt_ab, lt_ba;
    side_t       side_next;
    side_t       side_reg [0:DIV_LAT-1];

    logic [63:0] mul_val, div_val;
    logic        mul_sat, div_sat;
    logic [64:0] mdly_reg [0:MDLY-1];

    logic [63:0] res_val_next;
    logic        res_sat_next;
    logic [63:0] res_val_reg;
    logic        res_und_reg, res_sat_reg;

    // Global advance: hold everything while the output waits
    assign en       = !(vld_reg[TOTAL-1] && out_stall);
    assign in_stall = !en;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL; i++) vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < TOTAL; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Input stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg <= operation;
            a_reg  <= a_value;
            au_reg <= a_undef;
            b_reg  <= b_value;
            bu_reg <= b_undef;
            c_reg  <= c_value;
            cu_reg <= c_undef;
        end
    end

    // Operand preparation
    assign a_mag    = a_reg[63] ? 64'd0 - a_reg : a_reg;
    assign b_mag    = b_reg[63] ? 64'd0 - b_reg : b_reg;
    assign prod_neg = a_reg[63] ^ b_reg[63];
    assign either   = au_reg | bu_reg;
    assign sum      = a_reg + b_reg;
    assign diff     = a_reg - b_reg;
    assign lt_ab    = $signed(a_reg) < $signed(b_reg);
    assign lt_ba    = $signed(b_reg) < $signed(a_reg);
    assign rsum     = a_reg[63] ? a_reg - ROUND_BIAS : a_reg + ROUND_BIAS;
    // Toward zero: a negative value with a fraction moves up one unit
    assign rtrunc   = (rsum[63] && (rsum & FRAC_MASK) != 64'd0)
                    ? (rsum & ~FRAC_MASK) + ONE_Q : (rsum & ~FRAC_MASK);
    assign fsum     = a_reg + FLOOR_EPS;

    // Simple operations and unit selection
    always_comb
    begin
        side_next = '{kind: K_SIMPLE, value: 64'd0, undef: 1'b0, sat: 1'b0};
        unique case (op_reg)
            OP_ADD:
                if (au_reg && bu_reg) side_next.undef = 1'b1;
                else if (a_reg[63] == b_reg[63] && sum[63] != a_reg[63])
                begin
                    side_next.sat   = 1'b1;
                    side_next.value = a_reg[63] ? Q_MIN : Q_MAX;
                end
                else side_next.value = sum;
            OP_SUB:
                if (au_reg && bu_reg) side_next.undef = 1'b1;
                else if (a_reg[63] != b_reg[63] && diff[63] != a_reg[63])
                begin
                    side_next.sat   = 1'b1;
                    side_next.value = a_reg[63] ? Q_MIN : Q_MAX;
                end
                else side_next.value = diff;
            OP_NEG:
                if (au_reg) side_next.undef = 1'b1;
                else if (a_reg == Q_MIN)
                begin
                    side_next.sat   = 1'b1;
                    side_next.value = Q_MAX;
                end
                else side_next.value = 64'd0 - a_reg;
            OP_MUL:
                if (either) side_next.undef = 1'b1;
                else side_next.kind = K_MUL;
            OP_DIV:
                if (either) side_next.undef = 1'b1;
                else if (b_reg != 64'd0) side_next.kind = K_DIV;
            OP_LT:
                if (either) side_next.undef = 1'b1;
                else side_next.value = lt_ab ? ONE_Q : 64'd0;
            OP_LTE:
                if (either) side_next.undef = 1'b1;
                else side_next.value = !lt_ba ? ONE_Q : 64'd0;
            OP_GT:
                if (either) side_next.undef = 1'b1;
                else side_next.value = lt_ba ? ONE_Q : 64'd0;
            OP_GTE:
                if (either) side_next.undef = 1'b1;
                else side_next.value = !lt_ab ? ONE_Q : 64'd0;
            OP_EQ:
                if (either) side_next.undef = 1'b1;
                else side_next.value = (a_reg == b_reg) ? ONE_Q : 64'd0;
            OP_NEQ:
                if (either) side_next.undef = 1'b1;
                else side_next.value = (a_reg != b_reg) ? ONE_Q : 64'd0;
            OP_AND:
                if (either) side_next.undef = 1'b1;
                else side_next.value = (a_reg != 64'd0 && b_reg != 64'd0) ? ONE_Q : 64'd0;
            OP_OR:
                if (either) side_next.undef = 1'b1;
                else side_next.value = (a_reg != 64'd0 || b_reg != 64'd0) ? ONE_Q : 64'd0;
            OP_NOT:
                if (au_reg) side_next.undef = 1'b1;
                else side_next.value = (a_reg == 64'd0) ? ONE_Q : 64'd0;
            OP_COND:
                if (au_reg) side_next.undef = 1'b1;
                else if (a_reg != 64'd0)
                begin
                    side_next.value = b_reg;
                    side_next.undef = bu_reg;
                end
                else
                begin
                    side_next.value = c_reg;
                    side_next.undef = cu_reg;
                end
            OP_MAX:      side_next.value = lt_ab ? b_reg : a_reg;
            OP_MIN:      side_next.value = lt_ba ? b_reg : a_reg;
            OP_PRESENT:  side_next.value = !au_reg ? ONE_Q : 64'd0;
            OP_NULL:     side_next.value = au_reg ? ONE_Q : 64'd0;
            OP_ROUND:
                if (au_reg) side_next.undef = 1'b1;
                else if (rsum[63] != a_reg[63])
                begin
                    // Clamp lands on an integer boundary after truncation
                    side_next.sat   = 1'b1;
                    side_next.value = a_reg[63] ? Q_MIN : (Q_MAX & ~FRAC_MASK);
                end
                else side_next.value = rtrunc;
            OP_FLOOR:
                if (au_reg) side_next.undef = 1'b1;
                else if (!a_reg[63] && fsum[63]) side_next.value = Q_MAX & ~FRAC_MASK;
                else side_next.value = fsum & ~FRAC_MASK;
            OP_DEFTRUE:  side_next.value = (!au_reg && a_reg != 64'd0) ? ONE_Q : 64'd0;
            OP_DEFFALSE: side_next.value = (!au_reg && a_reg == 64'd0) ? ONE_Q : 64'd0;
            default:     side_next.value = 64'd0;
        endcase
    end

    // Side data delayed to line up with the divider output
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DIV_LAT; i++) side_reg[i] <= side_reg[i-1];
        end
    end

    tuva_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul
    (
        .clk   (clk),
        .en    (en),
        .x     (a_mag),
        .y     (b_mag),
        .neg   (prod_neg),
        .value (mul_val),
        .sat   (mul_sat)
    );

    tuva_div #(.FRACTION_BITS(FRACTION_BITS)) u_div
    (
        .clk   (clk),
        .en    (en),
        .x     (a_mag),
        .d     (b_mag),
        .neg   (prod_neg),
        .value (div_val),
        .sat   (div_sat)
    );

    // Multiplier results delayed to the divider latency
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mdly_reg[0] <= {mul_sat, mul_val};
            for (int i = 1; i < MDLY; i++) mdly_reg[i] <= mdly_reg[i-1];
        end
    end

    // Final selection
    always_comb
    begin
        unique case (side_reg[DIV_LAT-1].kind)
            K_MUL:
            begin
                res_val_next = mdly_reg[MDLY-1][63:0];
                res_sat_next = mdly_reg[MDLY-1][64];
            end
            K_DIV:
            begin
                res_val_next = div_val;
                res_sat_next = div_sat;
            end
            default:
            begin
                res_val_next = side_reg[DIV_LAT-1].value;
                res_sat_next = side_reg[DIV_LAT-1].sat;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_val_reg <= res_val_next;
            res_und_reg <= side_reg[DIV_LAT-1].undef;
            res_sat_reg <= res_sat_next;
        end
    end

    assign out_valid    = vld_reg[TOTAL-1];
    assign result_value = res_val_reg;
    assign result_undef = res_und_reg;
    assign saturated    = res_sat_reg;

    // Checks
    `TUVA_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall)
    `TUVA_ASSERT_IMP(a_undef_nosat, clk, rst_n, out_valid && result_undef, !saturated)
    `TUVA_ASSERT_NXT(a_hold_pipe, clk, rst_n, out_valid && out_stall, $stable(vld_reg[0]) && out_valid)

endmodule
